// ===== hdl/multi_column_radix_partitioner_defines.svh =====
// Assertion macros for the radix partitioner checker.
// Expect clk_i and rst_ni in the scope that uses them.
`ifndef MULTI_COLUMN_RADIX_PARTITIONER_DEFINES_SVH
`define MULTI_COLUMN_RADIX_PARTITIONER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define MCRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MCRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mcrp_pkg.sv =====
// Shared types, constants and field layout of the radix partitioner.
// No dependencies; imported by every module of the block.
package mcrp_pkg;

  localparam int PartBits   = 10;
  localparam int MaxColumns = 8;
  localparam int CountW     = 32;

  localparam int NumParts   = 1 << PartBits;
  localparam int ColIdxW    = 3;
  localparam int DigitW     = 3;
  localparam int DigitMaxW  = 7;
  localparam int NumColsW   = 4;
  localparam int DigPackW   = 24;
  localparam int ShiftW     = 6;
  localparam int WordW      = 32;
  localparam int HashW      = 64;
  localparam int PartFieldW = 10;

  // Configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegColumnsInUse   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegDigitBitsPacked = CfgIdxW'(1);

  // Input item layout in s_axis_tdata
  localparam int InChunkLo  = 0;
  localparam int InOffsetLo = InChunkLo + WordW;
  localparam int InColLo    = InOffsetLo + WordW;
  localparam int InNullBit  = InColLo + ColIdxW;
  localparam int InHashLo   = InNullBit + 1;
  localparam int InQueryLo  = InHashLo + HashW;
  localparam int InFieldsW  = InQueryLo + PartFieldW;
  localparam int InTdataW   = ((InFieldsW + 7) / 8) * 8;

  // Result item layout in m_axis_tdata
  localparam int OutFieldsW = 4 * WordW + PartFieldW;
  localparam int OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  localparam int OpW = 2;
  typedef enum logic [OpW-1:0] {
    OpColumn = 2'd0,
    OpQuery  = 2'd1,
    OpClear  = 2'd2
  } op_e;

  localparam logic KindPlace = 1'b0;
  localparam logic KindSize  = 1'b1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StProc
  } st_e;

  // Digit unit status towards the controller
  typedef struct packed {
    logic                in_use;
    logic                last;
    logic [PartBits-1:0] part;
  } dig_info_t;

  function automatic logic [DigitW-1:0] dig_width(input logic [DigPackW-1:0] packed_w,
                                                  input int unsigned        col);
    dig_width = packed_w[DigitW*col +: DigitW];
  endfunction

endpackage

// ===== hdl/mcrp_digit.sv =====
// Column digit extraction and partial partition id register.
// Depends on mcrp_pkg.
module mcrp_digit import mcrp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NumColsW-1:0] columns_in_use_i,
  input  logic [DigPackW-1:0] digit_bits_i,
  input  logic                upd_i,
  input  logic [ColIdxW-1:0]  column_index_i,
  input  logic                value_is_null_i,
  input  logic [HashW-1:0]    hash_value_i,
  output dig_info_t           info_o
);

  logic [PartBits-1:0]  partial_q, partial_d;
  logic [NumColsW-1:0]  ncol;
  logic [NumColsW-1:0]  col_ext;
  logic [ShiftW-1:0]    shift;
  logic [DigitW-1:0]    width_cur;
  logic [DigitMaxW-1:0] digit;
  logic [HashW-1:0]     shifted;
  logic [PartBits-1:0]  part_new;

  always_comb begin
    if (columns_in_use_i == '0) begin
      ncol = NumColsW'(1);
    end else if (columns_in_use_i > NumColsW'(MaxColumns)) begin
      ncol = NumColsW'(MaxColumns);
    end else begin
      ncol = columns_in_use_i;
    end
  end

  assign col_ext = NumColsW'(column_index_i);

  // Position of this digit: widths of the later columns in use
  always_comb begin
    shift = '0;
    for (int c = 0; c < MaxColumns; c++) begin
      if ((NumColsW'(c) > col_ext) && (NumColsW'(c) < ncol)) begin
        shift = shift + ShiftW'(dig_width(digit_bits_i, c));
      end
    end
  end

  always_comb begin
    width_cur = dig_width(digit_bits_i, 32'(column_index_i));
    digit     = value_is_null_i ? '0
              : hash_value_i[DigitMaxW-1:0] & DigitMaxW'((8'd1 << width_cur) - 8'd1);
    shifted   = HashW'(digit) << shift;
    part_new  = (column_index_i == '0) ? PartBits'(shifted)
              : (partial_q | PartBits'(shifted));
  end

  assign partial_d = (upd_i && info_o.in_use) ? part_new : partial_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
    end else begin
      partial_q <= partial_d;
    end
  end

  assign info_o.in_use = col_ext < ncol;
  assign info_o.last   = col_ext == (ncol - NumColsW'(1));
  assign info_o.part   = part_new;

endmodule

// ===== hdl/mcrp_count_ram.sv =====
// Partition counter memory: one write port, one registered read port.
// Depends on mcrp_pkg for depth and width.
module mcrp_count_ram import mcrp_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [PartBits-1:0] waddr_i,
  input  logic [CountW-1:0]   wdata_i,
  input  logic                re_i,
  input  logic [PartBits-1:0] raddr_i,
  output logic [CountW-1:0]   rdata_o
);

  logic [CountW-1:0] mem_q [NumParts];
  logic [CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/multi_column_radix_partitioner.sv =====
// Radix partitioner counting stage: top level with control and output register.
// Depends on mcrp_pkg, mcrp_digit and mcrp_count_ram.
//
// Use: each row arrives as one input item per partition column (tuser = operation,
// column value). When the row's last column in use is taken, one placement item
// leaves on the master side with the row id, its partition and its slot (the
// partition count before the row). A query item returns one size item; a clear
// item zeroes all counters and returns nothing.
// A row end or query reads its counter into the memory's read register; the
// result enters the output register once that is free, and a row end writes
// its count back, saturating. No input is taken meanwhile; a column value that
// does not end a row leaves the block idle. A clear item holds s_axis_tready low
// while all 1024 counters are swept one entry a cycle; reset starts the same sweep.
// A stalled receiver holds the result in the output register; input items are
// still taken up to the next row end or query, which waits in the counter stage
// until the register frees. Configuration writes are
// always taken (cfg_ready_o stays high) and belong to idle periods only.
module multi_column_radix_partitioner import mcrp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // Input items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: source_chunk, source_offset, column_index, value_is_null, hash_value,
  //        query_partition, zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // tuser: operation
  input  logic [OpW-1:0]       s_axis_tuser,
  // Result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: placed_chunk, placed_offset, partition_number, slot_in_partition,
  //        partition_rows, zero pad
  output logic [OutTdataW-1:0] m_axis_tdata,
  // tuser: result_kind
  output logic                 m_axis_tuser
);

  st_e                  st_q, st_d;
  logic [PartBits-1:0]  clr_cnt_q, clr_cnt_d;
  logic [NumColsW-1:0]  columns_q;
  logic [DigPackW-1:0]  digits_q;

  logic                 item_query_q;
  logic [WordW-1:0]     item_chunk_q, item_offset_q;
  logic [PartBits-1:0]  item_part_q;

  logic                 out_valid_q, out_valid_d;
  logic                 out_kind_q;
  logic [OutFieldsW-1:0] out_data_q;

  logic                 accept;
  op_e                  op;
  dig_info_t            dig_info;
  logic                 rd_en;
  logic [PartBits-1:0]  rd_addr;
  logic                 wr_en;
  logic [PartBits-1:0]  wr_addr;
  logic [CountW-1:0]    wr_data;
  logic [CountW-1:0]    old_cnt;
  logic                 out_free;
  logic                 proc_done;
  logic [WordW-1:0]     rows_clamped;

  localparam logic [CountW-1:0] CountMax = '1;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= NumColsW'(1);
      digits_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegColumnsInUse:    columns_q <= cfg_data_i[NumColsW-1:0];
        RegDigitBitsPacked: digits_q  <= cfg_data_i[DigPackW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign op     = op_e'(s_axis_tuser);

  mcrp_digit u_digit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .columns_in_use_i (columns_q),
    .digit_bits_i     (digits_q),
    .upd_i            (accept && (op == OpColumn)),
    .column_index_i   (s_axis_tdata[InColLo +: ColIdxW]),
    .value_is_null_i  (s_axis_tdata[InNullBit]),
    .hash_value_i     (s_axis_tdata[InHashLo +: HashW]),
    .info_o           (dig_info)
  );

  // A row end or a query reads its counter now and finishes in StProc
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = dig_info.part;
    if (accept) begin
      case (op)
        OpQuery: begin
          rd_en   = 1'b1;
          rd_addr = PartBits'(s_axis_tdata[InQueryLo +: PartFieldW]);
        end
        OpColumn: rd_en = dig_info.in_use && dig_info.last;
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_q || m_axis_tready;
  assign proc_done = (st_q == StProc) && out_free;

  // Next state
  always_comb begin
    st_d      = st_q;
    clr_cnt_d = clr_cnt_q;
    unique case (st_q)
      StClear: begin
        clr_cnt_d = clr_cnt_q + PartBits'(1);
        if (clr_cnt_q == '1) begin
          st_d = StIdle;
        end
      end
      StIdle: begin
        if (rd_en) begin
          st_d = StProc;
        end else if (accept && (op == OpClear)) begin
          st_d      = StClear;
          clr_cnt_d = '0;
        end
      end
      StProc: begin
        if (out_free) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = item_part_q;
    wr_data       = '0;
    unique case (st_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
      end
      StIdle: s_axis_tready = 1'b1;
      StProc: begin
        wr_en   = out_free && !item_query_q;
        wr_data = (old_cnt == CountMax) ? old_cnt : old_cnt + CountW'(1);
      end
      default: ;
    endcase
  end

  mcrp_count_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (old_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StClear;
      clr_cnt_q <= '0;
    end else begin
      st_q      <= st_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Hold the item being counted
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      item_query_q  <= (op == OpQuery);
      item_chunk_q  <= s_axis_tdata[InChunkLo +: WordW];
      item_offset_q <= s_axis_tdata[InOffsetLo +: WordW];
      item_part_q   <= rd_addr;
    end
  end

  assign rows_clamped = ((CountW > WordW) && ((old_cnt >> WordW) != '0)) ? '1
                      : WordW'(old_cnt);

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (proc_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_done) begin
      if (item_query_q) begin
        out_kind_q <= KindSize;
        out_data_q <= {rows_clamped, WordW'(0), PartFieldW'(item_part_q),
                       WordW'(0), WordW'(0)};
      end else begin
        out_kind_q <= KindPlace;
        out_data_q <= {WordW'(0), WordW'(old_cnt), PartFieldW'(item_part_q),
                       item_offset_q, item_chunk_q};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = OutTdataW'(out_data_q);

endmodule

// ===== hdl/mcrp_checker.sv =====
// Port-level checker for the radix partitioner, bound to the top level.
// Depends on mcrp_pkg and multi_column_radix_partitioner_defines.svh.
`include "multi_column_radix_partitioner_defines.svh"

module mcrp_checker import mcrp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_o,
  input logic [CfgIdxW-1:0]   cfg_index_i,
  input logic [CfgDataW-1:0]  cfg_data_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [InTdataW-1:0]  s_axis_tdata,
  input logic [OpW-1:0]       s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  localparam int SlotLo = 2 * WordW + PartFieldW;
  localparam int RowsLo = SlotLo + WordW;

  // Counter sweep follows reset and every clear item; a query blocks input while in flight
  `MCRP_ASSERT_SAME(a_sweep_after_reset, $rose(rst_ni), !s_axis_tready,
                    "input taken before the reset sweep")
  `MCRP_ASSERT_NEXT(a_sweep_after_clear,
                    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpClear),
                    !s_axis_tready, "input taken during a clear sweep")
  `MCRP_ASSERT_NEXT(a_query_blocks,
                    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OpQuery),
                    !s_axis_tready, "input taken while a query is in flight")
  // Size answers carry no row id and no slot
  `MCRP_ASSERT_SAME(a_size_fields, m_axis_tvalid && (m_axis_tuser == KindSize),
                    (m_axis_tdata[2*WordW-1:0] == '0) &&
                    (m_axis_tdata[SlotLo +: WordW] == '0),
                    "size answer with row fields set")
  `MCRP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                    "stalled result item changed")

endmodule

bind multi_column_radix_partitioner mcrp_checker u_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking bench for multi_column_radix_partitioner: rows, queries and clears
// on s_axis, checked against an in-bench partition counter model. Needs mcrp_pkg.
module testbench;
  import mcrp_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int OutOffsetLo = WordW;
  localparam int OutPartLo   = 2 * WordW;
  localparam int OutSlotLo   = OutPartLo + PartFieldW;
  localparam int OutRowsLo   = OutSlotLo + WordW;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [CountW-1:0] CountTop = {CountW{1'b1}};

  typedef struct {
    logic [OpW-1:0]     op;
    logic [WordW-1:0]   chunk;
    logic [WordW-1:0]   offset;
    logic [ColIdxW-1:0] col;
    logic               nul;
    logic [HashW-1:0]   hash;
    logic [PartFieldW-1:0] qpart;
  } part_item_t;

  typedef struct {
    logic                  kind;
    logic [WordW-1:0]      chunk;
    logic [WordW-1:0]      offset;
    logic [PartFieldW-1:0] part;
    logic [WordW-1:0]      slot;
    logic [WordW-1:0]      rows;
  } part_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]       s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  multi_column_radix_partitioner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Model state
  logic [NumColsW-1:0]   model_cols;
  logic [DigPackW-1:0]   model_digits;
  logic [PartBits-1:0]   model_partial;
  logic [CountW-1:0]     model_counts [NumParts];

  part_item_t   item_backlog [$];
  part_result_t awaited_results [$];
  part_item_t   cur_item;

  int   error_count = 0;
  int   cycle_count = 0;
  int   send_gap    = 0;
  int   recv_gap    = 0;
  bit   quiet       = 1'b0;
  bit   s_taken     = 1'b0;
  logic [WordW-1:0] chunk_no = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int effective_columns(input logic [NumColsW-1:0] cols);
    if (cols < 1) return 1;
    if (cols > MaxColumns) return MaxColumns;
    return int'(cols);
  endfunction

  function automatic logic [InTdataW-1:0] pack_item(input part_item_t it);
    logic [InTdataW-1:0] d;
    d = '0;
    d[InChunkLo +: WordW]       = it.chunk;
    d[InOffsetLo +: WordW]      = it.offset;
    d[InColLo +: ColIdxW]       = it.col;
    d[InNullBit]                = it.nul;
    d[InHashLo +: HashW]        = it.hash;
    d[InQueryLo +: PartFieldW]  = it.qpart;
    return d;
  endfunction

  // Advance the counter model by one accepted item
  task automatic partition_step(input logic [OpW-1:0] op, input logic [InTdataW-1:0] d);
    int                  ncol;
    int                  col;
    int                  shift;
    logic [DigitW-1:0]   w;
    logic [HashW-1:0]    digit;
    logic [PartBits-1:0] part;
    logic [CountW-1:0]   old;
    part_result_t        res;
    ncol = effective_columns(model_cols);
    if (op == OpClear) begin
      foreach (model_counts[i]) model_counts[i] = '0;
    end else if (op == OpQuery) begin
      part = d[InQueryLo +: PartBits];
      res = '{KindSize, '0, '0, PartFieldW'(part), '0, WordW'(model_counts[part])};
      awaited_results.push_back(res);
    end else if (op == OpColumn) begin
      col = int'(d[InColLo +: ColIdxW]);
      if (col < ncol) begin
        shift = 0;
        for (int c = col + 1; c < ncol; c++) shift += int'(model_digits[DigitW*c +: DigitW]);
        w = model_digits[DigitW*col +: DigitW];
        digit = d[InNullBit] ? '0 : (d[InHashLo +: HashW] & ((64'd1 << w) - 64'd1));
        digit = digit << shift;
        if (col == 0) model_partial = digit[PartBits-1:0];
        else model_partial = model_partial | digit[PartBits-1:0];
        if (col == ncol - 1) begin
          part = model_partial;
          old = model_counts[part];
          if (old != CountTop) model_counts[part] = old + 1'b1;
          res = '{KindPlace, d[InChunkLo +: WordW], d[InOffsetLo +: WordW],
                  PartFieldW'(part), WordW'(old), '0};
          awaited_results.push_back(res);
        end
      end
    end
  endtask

  task automatic report_field(input string name, input logic [WordW-1:0] exp_v,
                              input logic [WordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic check_result();
    part_result_t exp_r;
    part_result_t got;
    got.kind   = m_axis_tuser;
    got.chunk  = m_axis_tdata[0 +: WordW];
    got.offset = m_axis_tdata[OutOffsetLo +: WordW];
    got.part   = m_axis_tdata[OutPartLo +: PartFieldW];
    got.slot   = m_axis_tdata[OutSlotLo +: WordW];
    got.rows   = m_axis_tdata[OutRowsLo +: WordW];
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %b part %h",
               $realtime, got.kind, got.part);
      error_count++;
    end else begin
      exp_r = awaited_results.pop_front();
      report_field("result_kind", WordW'(exp_r.kind), WordW'(got.kind));
      report_field("placed_chunk", exp_r.chunk, got.chunk);
      report_field("placed_offset", exp_r.offset, got.offset);
      report_field("partition_number", WordW'(exp_r.part), WordW'(got.part));
      report_field("slot_in_partition", exp_r.slot, got.slot);
      report_field("partition_rows", exp_r.rows, got.rows);
    end
  endtask

  // Sample at the rising edge: results first, then the item just taken
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      s_taken = rst_ni && s_axis_tvalid && s_axis_tready;
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
      if (s_taken) partition_step(s_axis_tuser, s_axis_tdata);
      if (rst_ni && cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegColumnsInUse) model_cols = cfg_data_i[NumColsW-1:0];
        else if (cfg_index_i == RegDigitBitsPacked) model_digits = cfg_data_i[DigPackW-1:0];
      end
    end
  end

  // Sender: hold the item until taken, then advance or idle for a burst
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || s_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        cur_item = item_backlog.pop_front();
        s_axis_tdata  <= pack_item(cur_item);
        s_axis_tuser  <= cur_item.op;
        s_axis_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall in bursts of random length, always ready when quiet
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      recv_gap <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_item(input logic [OpW-1:0] op, input logic [WordW-1:0] chunk,
                           input logic [WordW-1:0] offset, input int col, input bit nul,
                           input logic [HashW-1:0] hash, input logic [PartFieldW-1:0] qpart);
    part_item_t it;
    it.op = op;
    it.chunk = chunk;
    it.offset = offset;
    it.col = ColIdxW'(col);
    it.nul = nul;
    it.hash = hash;
    it.qpart = qpart;
    item_backlog.push_back(it);
  endtask

  function automatic logic [HashW-1:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for all items taken, all results in, and the pipeline and sweep done
  task automatic settle();
    while (item_backlog.size() > 0 || s_axis_tvalid || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic add_row(input int ncol, input int upto);
    logic [WordW-1:0] offset;
    offset = ($urandom_range(0, 15) == 0) ? {WordW{1'b1}} : $urandom;
    if ($urandom_range(0, 31) == 0) chunk_no = {WordW{1'b1}};
    for (int c = 0; c < upto; c++)
      push_item(OpColumn, chunk_no, offset, c, $urandom_range(0, 7) == 0, rand_hash(),
                PartFieldW'($urandom));
    chunk_no = chunk_no + 1'b1;
  endtask

  task automatic add_traffic(input int count, input int ncol);
    int made;
    int r;
    logic [PartFieldW-1:0] q;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_row(ncol, ncol);
        made += ncol;
      end else if (r < 78) begin
        // broken row: may stop short of the last column
        r = $urandom_range(1, ncol);
        add_row(ncol, r);
        made += r;
      end else if (r < 89) begin
        q = ($urandom_range(0, 1) == 0) ? PartFieldW'($urandom_range(0, 15))
                                        : PartFieldW'($urandom);
        push_item(OpQuery, $urandom, $urandom, $urandom_range(0, 7), $urandom_range(0, 1),
                  rand_hash(), q);
        made++;
      end else if (r < 95) begin
        r = $urandom_range(0, 7);
        push_item(OpColumn, $urandom, $urandom, r, $urandom_range(0, 1), rand_hash(),
                  PartFieldW'($urandom));
        if (r < ncol) made++;
      end else if (r < 98) begin
        push_item(OpUnused, $urandom, $urandom, $urandom_range(0, 7), $urandom_range(0, 1),
                  rand_hash(), PartFieldW'($urandom));
      end else begin
        push_item(OpClear, $urandom, $urandom, $urandom_range(0, 7), $urandom_range(0, 1),
                  rand_hash(), PartFieldW'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    logic [NumColsW-1:0] cols;
    logic [DigPackW-1:0] digits;
    int mode;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpColumn;
    m_axis_tready = 1'b0;
    model_cols    = NumColsW'(1);
    model_digits  = '0;
    model_partial = '0;
    foreach (model_counts[i]) model_counts[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one column of zero width, every row lands in partition 0
    push_item(OpQuery, $urandom, $urandom, 0, 1'b0, rand_hash(), {PartFieldW{1'b1}});
    push_item(OpColumn, '0, '0, 0, 1'b0, {HashW{1'b1}}, '0);
    push_item(OpColumn, {WordW{1'b1}}, {WordW{1'b1}}, 0, 1'b1, '0, {PartFieldW{1'b1}});
    push_item(OpColumn, $urandom, $urandom, 1, 1'b0, rand_hash(), '0);
    push_item(OpUnused, $urandom, $urandom, 0, 1'b0, rand_hash(), '0);
    push_item(OpQuery, $urandom, $urandom, 0, 1'b0, rand_hash(), '0);
    settle();

    // Three columns of widths 3, 2, 5
    write_reg(RegColumnsInUse, CfgDataW'({$urandom, 4'd3}));
    write_reg(RegDigitBitsPacked, {8'hA5, 24'(3 | (2 << 3) | (5 << 6))});
    push_item(OpColumn, 32'd7, 32'd1, 0, 1'b0, {HashW{1'b1}}, '0);
    push_item(OpColumn, 32'd7, 32'd1, 1, 1'b0, 64'h2, '0);
    push_item(OpColumn, 32'd7, 32'd1, 2, 1'b0, {HashW{1'b1}}, '0);
    push_item(OpColumn, 32'd8, 32'd2, 0, 1'b1, {HashW{1'b1}}, '0);
    push_item(OpColumn, 32'd8, 32'd2, 1, 1'b1, {HashW{1'b1}}, '0);
    push_item(OpColumn, 32'd8, 32'd2, 2, 1'b0, '0, '0);
    push_item(OpQuery, '0, '0, 0, 1'b0, '0, 10'd991);
    push_item(OpClear, '0, '0, 0, 1'b0, '0, '0);
    push_item(OpQuery, '0, '0, 0, 1'b0, '0, 10'd991);
    // last column alone: ORs into the kept partial id
    push_item(OpColumn, 32'd9, 32'd3, 2, 1'b0, 64'h5, '0);
    settle();

    // Eight columns of width 7: the id is cut to its low bits
    write_reg(RegColumnsInUse, 32'd8);
    write_reg(RegDigitBitsPacked, {8'h00, 24'hFFFFFF});
    for (int c = 0; c < 8; c++)
      push_item(OpColumn, 32'hFFFF_FFFF, 32'h1234_5678, c, 1'b0, {HashW{1'b1}}, '0);
    settle();

    // Zero columns acts as one
    write_reg(RegColumnsInUse, 32'd0);
    push_item(OpColumn, 32'd10, 32'd0, 0, 1'b0, {HashW{1'b1}}, '0);
    push_item(OpColumn, 32'd10, 32'd0, 1, 1'b0, {HashW{1'b1}}, '0);

    for (int p = 0; p < 12; p++) begin
      if (p == 11) quiet = 1'b1;
      settle();
      mode = $urandom_range(0, 5);
      if (mode == 0) cols = NumColsW'(8);
      else if (mode == 1) cols = {NumColsW{1'b1}};
      else if (mode == 2) cols = '0;
      else cols = NumColsW'($urandom_range(1, 8));
      mode = $urandom_range(0, 4);
      digits = '0;
      if (mode == 0) digits = {DigPackW{1'b1}};
      else if (mode == 1) digits = '0;
      else if (mode == 2) digits = DigPackW'($urandom);
      else
        for (int c = 0; c < MaxColumns; c++)
          digits[DigitW*c +: DigitW] = DigitW'($urandom_range(0, 2));
      write_reg(RegColumnsInUse, CfgDataW'({$urandom, cols}));
      write_reg(RegDigitBitsPacked, CfgDataW'({$urandom, digits}));
      add_traffic(155, effective_columns(cols));
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mcrp_pkg.sv
hdl/mcrp_digit.sv
hdl/mcrp_count_ram.sv
hdl/multi_column_radix_partitioner.sv
hdl/mcrp_checker.sv
tb/testbench.sv
